### hdl/cotd_pkg.sv
// Shared codes, constants and the debounce helper for the over-temperature derate controller.
`default_nettype none
package cotd_pkg;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_DERATE = 2'd1;
    localparam logic [1:0] ST_STOP   = 2'd2;

    localparam logic [14:0] CUR_FULL   = 15'd32000;
    localparam logic [14:0] CUR_DERATE = 15'd25000;
    localparam logic [14:0] CUR_ZERO   = 15'd0;

    localparam int NUM_REGS   = 8;
    localparam int NUM_THR    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GUN_RELEASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUN_RECOVER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUN_DERATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GUN_STOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_RECOVER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_DERATE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd7;

    localparam logic [7:0]  RST_GUN_RELEASE = 8'd60;
    localparam logic [7:0]  RST_GUN_RECOVER = 8'd75;
    localparam logic [7:0]  RST_GUN_DERATE  = 8'd90;
    localparam logic [7:0]  RST_GUN_STOP    = 8'd105;
    localparam logic [7:0]  RST_ENV_RECOVER = 8'd65;
    localparam logic [7:0]  RST_ENV_DERATE  = 8'd85;
    localparam logic [7:0]  RST_DEBOUNCE    = 8'd3;
    localparam logic [23:0] RST_HOLD        = 24'd30000;

    typedef struct packed {
        logic       level;
        logic [7:0] count;
    } t_deb;

    function automatic t_deb f_debounce(input logic raw, input logic level,
                                        input logic [7:0] count, input logic [7:0] need);
        t_deb r;
        r.level = level;
        r.count = count;
        if (raw == level) begin
            r.count = 8'd0;
        end else begin
            if (count != 8'hFF) begin
                r.count = count + 8'd1;
            end
            if (r.count >= need) begin
                r.level = raw;
                r.count = 8'd0;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/charger_overtemp_derate_controller.sv
// Top level of the charger over-temperature derate controller.
// Pipeline: each input is registered into stage 1 as the RAM's registered read of its
// port state runs; stage 1 loads the output register when the output is free or taken.
// Throughput: one sample per cycle unless the output stalls; per-port state is read
// from a RAM, updated, written back, and forwarded to a same-port follower.
// Reset (synchronous, active low): registers take their reset values, per-port
// valid bits clear so every port reads as all-zero state; no clearing pass.
`default_nettype none
module charger_overtemp_derate_controller
    import cotd_pkg::*;
#(
    parameter int NUM_PORTS  = 4,
    parameter int TIMER_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [1:0] port_index, [9:2] gun_temperature, [17:10] env_temperature, [23:18] zero
    input  wire logic [23:0]           s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [1:0] port_out, [3:2] gun_state, [5:4] env_state, [20:6] current_limit_ma,
    // [21] gun_fault_set, [22] gun_fault_clear, [23] zero
    output logic      [23:0]           m_axis_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int TB = TIMER_BITS;

    typedef struct packed {
        logic [1:0]      gun_mode;
        logic [1:0]      gun_prev;
        logic            gun_first;
        logic [TB-1:0]   gun_high;
        logic [TB-1:0]   gun_low;
        logic [3:0]      gun_lvl;
        logic [3:0][7:0] gun_cnt;
        logic [1:0]      env_mode;
        logic            env_first;
        logic [TB-1:0]   env_high;
        logic [TB-1:0]   env_low;
        logic [1:0]      env_lvl;
        logic [1:0][7:0] env_cnt;
    } t_port_state;

    localparam int SW = $bits(t_port_state);

    function automatic logic [TB-1:0] f_tinc(input logic [TB-1:0] t);
        return (&t) ? t : t + TB'(1);
    endfunction

    function automatic logic f_timeout(input logic [TB-1:0] t, input logic [23:0] hold);
        return 32'(t) >= 32'(hold);
    endfunction

    logic [7:0]  r_thr [NUM_THR];
    logic [7:0]  r_debounce;
    logic [23:0] r_hold;

    logic [NUM_PORTS-1:0] r_valid;

    logic             r_s1_valid;
    logic [1:0]       r_s1_port;
    logic [7:0]       r_s1_gun_temp;
    logic [7:0]       r_s1_env_temp;
    logic             r_s1_in_range;
    logic             r_s1_ent_valid;
    logic             r_s1_fwd;
    t_port_state      r_fwd_state;

    logic             r_out_valid;
    logic [23:0]      r_out_data;

    logic             in_xfer;
    logic             s1_adv;
    logic [1:0]       in_port;
    logic             in_range;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    s1_addr;
    logic [SW-1:0]    ram_rdata;
    t_port_state      cur;
    t_port_state      nx;
    t_deb             deb;
    logic [1:0]       gs;
    logic [1:0]       es;
    logic [14:0]      cur_ma;
    logic             fset;
    logic             fclr;

    assign in_port     = s_axis_tdata[1:0];
    assign in_range    = 32'(in_port) < NUM_PORTS;
    assign in_addr     = AW'(in_port);
    assign s1_addr     = AW'(r_s1_port);

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    cotd_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_PORTS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv && r_s1_in_range),
        .i_wr_addr (s1_addr),
        .i_wr_data (nx),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_addr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        if (r_s1_fwd) begin
            cur = r_fwd_state;
        end else if (r_s1_ent_valid) begin
            cur = t_port_state'(ram_rdata);
        end else begin
            cur = '0;
        end
    end

    always_comb begin
        deb = '0;
        nx  = cur;
        for (int i = 0; i < 4; i++) begin
            deb = f_debounce(r_s1_gun_temp >= r_thr[i], cur.gun_lvl[i], cur.gun_cnt[i],
                             r_debounce);
            nx.gun_lvl[i] = deb.level;
            nx.gun_cnt[i] = deb.count;
        end
        for (int i = 0; i < 2; i++) begin
            deb = f_debounce(r_s1_env_temp >= r_thr[4 + i], cur.env_lvl[i], cur.env_cnt[i],
                             r_debounce);
            nx.env_lvl[i] = deb.level;
            nx.env_cnt[i] = deb.count;
        end

        case (cur.gun_mode)
            ST_NORMAL: begin
                if (nx.gun_lvl[2]) begin
                    if (nx.gun_lvl[3]) begin
                        nx.gun_mode = ST_STOP;
                    end else begin
                        nx.gun_first = 1'b1;
                        nx.gun_mode  = ST_DERATE;
                        nx.gun_high  = '0;
                        nx.gun_low   = '0;
                    end
                end
            end
            ST_DERATE: begin
                nx.gun_high = f_tinc(cur.gun_high);
                nx.gun_low  = f_tinc(cur.gun_low);
                if (nx.gun_lvl[3]) begin
                    nx.gun_mode = ST_STOP;
                end
                if (!cur.gun_first && !nx.gun_lvl[2]) begin
                    nx.gun_high = '0;
                end
                if (f_timeout(nx.gun_high, r_hold)) begin
                    if (nx.gun_lvl[2]) begin
                        nx.gun_mode = ST_STOP;
                    end
                    nx.gun_first = 1'b0;
                end
                if (nx.gun_lvl[1]) begin
                    nx.gun_low = '0;
                end
                if (f_timeout(nx.gun_low, r_hold) && !nx.gun_lvl[1]) begin
                    nx.gun_mode = ST_NORMAL;
                end
            end
            ST_STOP: begin
                if (!nx.gun_lvl[0]) begin
                    nx.gun_mode = ST_NORMAL;
                end
            end
            default: begin
            end
        endcase

        case (cur.env_mode)
            ST_NORMAL: begin
                if (nx.env_lvl[1]) begin
                    nx.env_mode  = ST_DERATE;
                    nx.env_high  = '0;
                    nx.env_low   = '0;
                    nx.env_first = 1'b1;
                end
            end
            ST_DERATE: begin
                nx.env_high = f_tinc(cur.env_high);
                nx.env_low  = f_tinc(cur.env_low);
                if (!cur.env_first && !nx.env_lvl[1]) begin
                    nx.env_high = '0;
                end
                if (f_timeout(nx.env_high, r_hold)) begin
                    if (nx.env_lvl[1]) begin
                        nx.env_mode = ST_STOP;
                    end
                    nx.env_first = 1'b0;
                end
                if (nx.env_lvl[0]) begin
                    nx.env_low = '0;
                end
                if (f_timeout(nx.env_low, r_hold) && !nx.env_lvl[0]) begin
                    nx.env_mode = ST_NORMAL;
                end
            end
            ST_STOP: begin
                if (!nx.env_lvl[0]) begin
                    nx.env_mode = ST_NORMAL;
                end
            end
            default: begin
            end
        endcase

        fset = 1'b0;
        fclr = 1'b0;
        if (nx.gun_mode != cur.gun_prev) begin
            nx.gun_prev = nx.gun_mode;
            fset        = (nx.gun_mode == ST_STOP);
            fclr        = (nx.gun_mode == ST_NORMAL);
        end

        gs = nx.gun_mode;
        es = nx.env_mode;
        if (!r_s1_in_range) begin
            gs   = ST_NORMAL;
            es   = ST_NORMAL;
            fset = 1'b0;
            fclr = 1'b0;
        end

        if (gs == ST_DERATE || es == ST_DERATE) begin
            cur_ma = CUR_DERATE;
        end else if (gs == ST_STOP) begin
            cur_ma = CUR_ZERO;
        end else begin
            cur_ma = CUR_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[REG_GUN_RELEASE] <= RST_GUN_RELEASE;
            r_thr[REG_GUN_RECOVER] <= RST_GUN_RECOVER;
            r_thr[REG_GUN_DERATE]  <= RST_GUN_DERATE;
            r_thr[REG_GUN_STOP]    <= RST_GUN_STOP;
            r_thr[REG_ENV_RECOVER] <= RST_ENV_RECOVER;
            r_thr[REG_ENV_DERATE]  <= RST_ENV_DERATE;
            r_debounce             <= RST_DEBOUNCE;
            r_hold                 <= RST_HOLD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GUN_RELEASE: r_thr[REG_GUN_RELEASE] <= i_cfg_wdata[7:0];
                REG_GUN_RECOVER: r_thr[REG_GUN_RECOVER] <= i_cfg_wdata[7:0];
                REG_GUN_DERATE:  r_thr[REG_GUN_DERATE]  <= i_cfg_wdata[7:0];
                REG_GUN_STOP:    r_thr[REG_GUN_STOP]    <= i_cfg_wdata[7:0];
                REG_ENV_RECOVER: r_thr[REG_ENV_RECOVER] <= i_cfg_wdata[7:0];
                REG_ENV_DERATE:  r_thr[REG_ENV_DERATE]  <= i_cfg_wdata[7:0];
                REG_DEBOUNCE:    r_debounce             <= i_cfg_wdata[7:0];
                REG_HOLD:        r_hold                 <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv && r_s1_in_range) begin
                r_valid[s1_addr] <= 1'b1;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_port      <= in_port;
            r_s1_gun_temp  <= s_axis_tdata[9:2];
            r_s1_env_temp  <= s_axis_tdata[17:10];
            r_s1_in_range  <= in_range;
            r_s1_ent_valid <= in_range && r_valid[in_addr];
            r_s1_fwd       <= s1_adv && r_s1_in_range && (r_s1_port == in_port);
        end
        if (s1_adv) begin
            r_fwd_state <= nx;
            r_out_data  <= {1'b0, fclr, fset, cur_ma, es, gs, r_s1_port};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

### hdl/cotd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cotd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### test/tb_charger_overtemp_derate_controller.sv
// Self-checking testbench for the charger over-temperature derate controller.
`timescale 1ns / 1ps

module tb_charger_overtemp_derate_controller;
    import cotd_pkg::*;

    localparam int PORTS = 4;

    localparam int GUN_LV_RELEASE = 0;
    localparam int GUN_LV_RECOVER = 1;
    localparam int GUN_LV_DERATE  = 2;
    localparam int GUN_LV_STOP    = 3;
    localparam int ENV_LV_RECOVER = 0;
    localparam int ENV_LV_DERATE  = 1;

    typedef struct packed {
        logic        gun_fault_clear;
        logic        gun_fault_set;
        logic [14:0] current_ma;
        logic [1:0]  env_state;
        logic [1:0]  gun_state;
        logic [1:0]  port;
    } t_derate_report;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] port_index, [9:2] gun_temperature, [17:10] env_temperature, [23:18] zero
    logic [23:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] port_out, [3:2] gun_state, [5:4] env_state, [20:6] current_limit_ma,
    // [21] gun_fault_set, [22] gun_fault_clear, [23] zero
    logic [23:0]           m_axis_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    charger_overtemp_derate_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    logic [23:0]    reg_copy [NUM_REGS];
    logic [1:0]     gun_mode_q     [PORTS];
    logic [1:0]     gun_seen_mode  [PORTS];
    logic           gun_hold_armed [PORTS];
    logic [23:0]    gun_hot_timer  [PORTS];
    logic [23:0]    gun_cool_timer [PORTS];
    logic           gun_lvl        [PORTS][4];
    logic [7:0]     gun_cnt        [PORTS][4];
    logic [1:0]     env_mode_q     [PORTS];
    logic           env_hold_armed [PORTS];
    logic [23:0]    env_hot_timer  [PORTS];
    logic [23:0]    env_cool_timer [PORTS];
    logic           env_lvl        [PORTS][2];
    logic [7:0]     env_cnt        [PORTS][2];

    logic [23:0]    pending_samples [$];
    t_derate_report expected_reports [$];
    int             mismatch_count = 0;
    int             src_idle_left = 0;
    int             sink_stall_left = 0;
    bit             src_steady = 1'b0;
    bit             sink_steady = 1'b0;
    logic           ready_next;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_charger_overtemp_derate_controller NOT OK");
        $finish;
    end

    function automatic void init_model();
        reg_copy[REG_GUN_RELEASE] = 24'(RST_GUN_RELEASE);
        reg_copy[REG_GUN_RECOVER] = 24'(RST_GUN_RECOVER);
        reg_copy[REG_GUN_DERATE]  = 24'(RST_GUN_DERATE);
        reg_copy[REG_GUN_STOP]    = 24'(RST_GUN_STOP);
        reg_copy[REG_ENV_RECOVER] = 24'(RST_ENV_RECOVER);
        reg_copy[REG_ENV_DERATE]  = 24'(RST_ENV_DERATE);
        reg_copy[REG_DEBOUNCE]    = 24'(RST_DEBOUNCE);
        reg_copy[REG_HOLD]        = RST_HOLD;
        for (int p = 0; p < PORTS; p++) begin
            gun_mode_q[p]     = ST_NORMAL;
            gun_seen_mode[p]  = ST_NORMAL;
            gun_hold_armed[p] = 1'b0;
            gun_hot_timer[p]  = '0;
            gun_cool_timer[p] = '0;
            env_mode_q[p]     = ST_NORMAL;
            env_hold_armed[p] = 1'b0;
            env_hot_timer[p]  = '0;
            env_cool_timer[p] = '0;
            for (int k = 0; k < 4; k++) begin
                gun_lvl[p][k] = 1'b0;
                gun_cnt[p][k] = '0;
            end
            for (int k = 0; k < 2; k++) begin
                env_lvl[p][k] = 1'b0;
                env_cnt[p][k] = '0;
            end
        end
    endfunction

    // {level, count} after one comparison
    function automatic logic [8:0] filter_step(input logic raw, input logic level,
                                               input logic [7:0] count);
        logic [7:0] n;
        if (raw == level)
            return {level, 8'd0};
        n = (count == 8'hFF) ? count : count + 8'd1;
        if (n >= reg_copy[REG_DEBOUNCE][7:0])
            return {raw, 8'd0};
        return {level, n};
    endfunction

    function automatic logic [23:0] bump(input logic [23:0] t);
        return (t == 24'hFF_FFFF) ? t : t + 24'd1;
    endfunction

    function automatic t_derate_report predict_derate(input logic [1:0] p,
                                                      input logic [7:0] gt,
                                                      input logic [7:0] et);
        t_derate_report r;
        logic [23:0]    hold;
        hold = reg_copy[REG_HOLD];
        for (int k = 0; k < 4; k++)
            {gun_lvl[p][k], gun_cnt[p][k]} = filter_step(
                gt >= reg_copy[REG_GUN_RELEASE + k][7:0], gun_lvl[p][k], gun_cnt[p][k]);
        for (int k = 0; k < 2; k++)
            {env_lvl[p][k], env_cnt[p][k]} = filter_step(
                et >= reg_copy[REG_ENV_RECOVER + k][7:0], env_lvl[p][k], env_cnt[p][k]);

        case (gun_mode_q[p])
            ST_NORMAL: begin
                if (gun_lvl[p][GUN_LV_DERATE]) begin
                    if (gun_lvl[p][GUN_LV_STOP]) begin
                        gun_mode_q[p] = ST_STOP;
                    end else begin
                        gun_hold_armed[p] = 1'b1;
                        gun_mode_q[p]     = ST_DERATE;
                        gun_hot_timer[p]  = '0;
                        gun_cool_timer[p] = '0;
                    end
                end
            end
            ST_DERATE: begin
                gun_hot_timer[p]  = bump(gun_hot_timer[p]);
                gun_cool_timer[p] = bump(gun_cool_timer[p]);
                if (gun_lvl[p][GUN_LV_STOP])
                    gun_mode_q[p] = ST_STOP;
                if (!gun_hold_armed[p] && !gun_lvl[p][GUN_LV_DERATE])
                    gun_hot_timer[p] = '0;
                if (gun_hot_timer[p] >= hold) begin
                    if (gun_lvl[p][GUN_LV_DERATE])
                        gun_mode_q[p] = ST_STOP;
                    gun_hold_armed[p] = 1'b0;
                end
                if (gun_lvl[p][GUN_LV_RECOVER])
                    gun_cool_timer[p] = '0;
                if (gun_cool_timer[p] >= hold && !gun_lvl[p][GUN_LV_RECOVER])
                    gun_mode_q[p] = ST_NORMAL;
            end
            ST_STOP: begin
                if (!gun_lvl[p][GUN_LV_RELEASE])
                    gun_mode_q[p] = ST_NORMAL;
            end
            default: ;
        endcase

        case (env_mode_q[p])
            ST_NORMAL: begin
                if (env_lvl[p][ENV_LV_DERATE]) begin
                    env_mode_q[p]     = ST_DERATE;
                    env_hot_timer[p]  = '0;
                    env_cool_timer[p] = '0;
                    env_hold_armed[p] = 1'b1;
                end
            end
            ST_DERATE: begin
                env_hot_timer[p]  = bump(env_hot_timer[p]);
                env_cool_timer[p] = bump(env_cool_timer[p]);
                if (!env_hold_armed[p] && !env_lvl[p][ENV_LV_DERATE])
                    env_hot_timer[p] = '0;
                if (env_hot_timer[p] >= hold) begin
                    if (env_lvl[p][ENV_LV_DERATE])
                        env_mode_q[p] = ST_STOP;
                    env_hold_armed[p] = 1'b0;
                end
                if (env_lvl[p][ENV_LV_RECOVER])
                    env_cool_timer[p] = '0;
                if (env_cool_timer[p] >= hold && !env_lvl[p][ENV_LV_RECOVER])
                    env_mode_q[p] = ST_NORMAL;
            end
            ST_STOP: begin
                if (!env_lvl[p][ENV_LV_RECOVER])
                    env_mode_q[p] = ST_NORMAL;
            end
            default: ;
        endcase

        r.port            = p;
        r.gun_state       = gun_mode_q[p];
        r.env_state       = env_mode_q[p];
        r.gun_fault_set   = 1'b0;
        r.gun_fault_clear = 1'b0;
        if (gun_mode_q[p] != gun_seen_mode[p]) begin
            gun_seen_mode[p]  = gun_mode_q[p];
            r.gun_fault_set   = (gun_mode_q[p] == ST_STOP);
            r.gun_fault_clear = (gun_mode_q[p] == ST_NORMAL);
        end
        if (r.gun_state == ST_DERATE || r.env_state == ST_DERATE)
            r.current_ma = CUR_DERATE;
        else if (r.gun_state == ST_STOP)
            r.current_ma = CUR_ZERO;
        else
            r.current_ma = CUR_FULL;
        return r;
    endfunction

    function automatic void check_report(input logic [23:0] word);
        t_derate_report got;
        t_derate_report exp_r;
        got = t_derate_report'(word[22:0]);
        if (expected_reports.size() == 0) begin
            $error("result transfer with nothing expected: %h", word);
            mismatch_count++;
            return;
        end
        exp_r = expected_reports.pop_front();
        if (got.port != exp_r.port) begin
            $error("port_out: expected %0d, got %0d", exp_r.port, got.port);
            mismatch_count++;
        end
        if (got.gun_state != exp_r.gun_state) begin
            $error("gun_state: expected %0d, got %0d", exp_r.gun_state, got.gun_state);
            mismatch_count++;
        end
        if (got.env_state != exp_r.env_state) begin
            $error("env_state: expected %0d, got %0d", exp_r.env_state, got.env_state);
            mismatch_count++;
        end
        if (got.current_ma != exp_r.current_ma) begin
            $error("current_limit_ma: expected %0d, got %0d", exp_r.current_ma,
                   got.current_ma);
            mismatch_count++;
        end
        if (got.gun_fault_set != exp_r.gun_fault_set) begin
            $error("gun_fault_set: expected %0d, got %0d", exp_r.gun_fault_set,
                   got.gun_fault_set);
            mismatch_count++;
        end
        if (got.gun_fault_clear != exp_r.gun_fault_clear) begin
            $error("gun_fault_clear: expected %0d, got %0d", exp_r.gun_fault_clear,
                   got.gun_fault_clear);
            mismatch_count++;
        end
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(predict_derate(s_axis_tdata[1:0],
                                                          s_axis_tdata[9:2],
                                                          s_axis_tdata[17:10]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_idle_left > 0) begin
                    src_idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_axis_tdata  <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        src_steady = !src_steady;
                    src_idle_left = src_steady ? 0 : draw_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            if ($urandom_range(0, 99) == 0)
                sink_steady = !sink_steady;
            ready_next = 1'b1;
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                ready_next = 1'b0;
            end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                sink_stall_left = draw_gap();
                ready_next = 1'b0;
            end
            m_axis_tready <= ready_next;
        end
    end

    function automatic void push_sample(input logic [1:0] p, input logic [7:0] gt,
                                        input logic [7:0] et);
        pending_samples.push_back({6'd0, et, gt, p});
    endfunction

    function automatic logic [7:0] clip8(input int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // temperature close to one of a sensor's thresholds, sometimes anywhere
    function automatic logic [7:0] near_threshold(input int first, input int count);
        if ($urandom_range(0, 9) < 2)
            return 8'($urandom);
        return clip8(int'(reg_copy[first + $urandom_range(0, count - 1)][7:0])
                     + $urandom_range(0, 4) - 2);
    endfunction

    function automatic logic [7:0] jitter(input logic [7:0] v);
        if ($urandom_range(0, 4) != 0)
            return v;
        return clip8(int'(v) + ($urandom_range(0, 1) ? 1 : -1));
    endfunction

    task automatic queue_bursts(input int total);
        int         n;
        int         len;
        int         lim;
        logic [1:0] p;
        logic [7:0] gbase;
        logic [7:0] ebase;
        n = 0;
        while (n < total) begin
            p = 2'($urandom);
            if ($urandom_range(0, 99) < 15) begin
                push_sample(p, 8'($urandom), 8'($urandom));
                n++;
            end else begin
                gbase = near_threshold(REG_GUN_RELEASE, 4);
                ebase = near_threshold(REG_ENV_RECOVER, 2);
                lim = 2 * int'(reg_copy[REG_DEBOUNCE]) + int'(reg_copy[REG_HOLD]) + 4;
                len = $urandom_range(1, (lim > 24) ? 24 : lim);
                for (int k = 0; k < len; k++)
                    push_sample(p, jitter(gbase), jitter(ebase));
                n += len;
            end
        end
    endtask

    task automatic drain_and_settle();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        reg_copy[idx] = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] rel, input logic [7:0] rec,
                                input logic [7:0] der, input logic [7:0] stp,
                                input logic [7:0] erec, input logic [7:0] eder,
                                input logic [7:0] deb, input logic [23:0] hold);
        write_reg(REG_GUN_RELEASE, {16'd0, rel});
        write_reg(REG_GUN_RECOVER, {16'd0, rec});
        write_reg(REG_GUN_DERATE, {16'd0, der});
        write_reg(REG_GUN_STOP, {16'd0, stp});
        write_reg(REG_ENV_RECOVER, {16'd0, erec});
        write_reg(REG_ENV_DERATE, {16'd0, eder});
        write_reg(REG_DEBOUNCE, {16'd0, deb});
        write_reg(REG_HOLD, hold);
    endtask

    function automatic logic [7:0] extreme_thr();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] rel;
        logic [7:0] rec;
        logic [7:0] der;
        init_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: straight to stop and back, then derate on both sensors
        repeat (3) push_sample(2'd0, 8'd255, 8'd0);
        repeat (3) push_sample(2'd0, 8'd0, 8'd255);
        repeat (4) push_sample(2'd1, 8'd95, 8'd70);
        // alternating readings keep clearing the debounce counters
        repeat (2) begin
            push_sample(2'd2, 8'd255, 8'd255);
            push_sample(2'd2, 8'd0, 8'd0);
        end
        push_sample(2'd3, 8'd104, 8'd86);
        push_sample(2'd3, 8'd105, 8'd85);
        push_sample(2'd3, 8'd106, 8'd84);
        drain_and_settle();

        // fastest filter and shortest hold
        apply_config(8'd40, 8'd60, 8'd80, 8'd120, 8'd50, 8'd90, 8'd1, 24'd1);
        queue_bursts(180);
        drain_and_settle();

        rel = $urandom_range(20, 80);
        rec = clip8(int'(rel) + $urandom_range(0, 30));
        der = clip8(int'(rec) + $urandom_range(0, 30));
        apply_config(rel, rec, der, clip8(int'(der) + $urandom_range(0, 40)),
                     8'($urandom_range(30, 90)), 8'($urandom_range(90, 160)),
                     8'($urandom_range(2, 4)), 24'($urandom_range(2, 12)));
        queue_bursts(180);
        drain_and_settle();

        // slowest filter and longest hold: every comparison is true with these thresholds
        apply_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 24'hFF_FFFF);
        for (int k = 0; k < 260; k++) begin
            push_sample(2'd2, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 7) == 0)
                push_sample(2'($urandom), 8'($urandom), 8'($urandom));
        end
        drain_and_settle();

        apply_config(extreme_thr(), extreme_thr(), extreme_thr(), extreme_thr(),
                     extreme_thr(), extreme_thr(), 8'($urandom_range(1, 3)),
                     24'($urandom_range(1, 6)));
        queue_bursts(180);
        drain_and_settle();

        if (mismatch_count == 0)
            $display("tb_charger_overtemp_derate_controller OK");
        else
            $display("tb_charger_overtemp_derate_controller NOT OK");
        $finish;
    end

endmodule

### filelist.f
hdl/cotd_pkg.sv
hdl/cotd_ram.sv
hdl/charger_overtemp_derate_controller.sv
test/tb_charger_overtemp_derate_controller.sv
